@@ hw/rtl/morse_pkg.sv @@
// Morse codec package: symbol codes, microcode word format, code tables.
package morse_pkg;

    localparam int UPC_W = 3;

    typedef logic [UPC_W-1:0] upc_t;
    typedef logic [1:0]       sym_t;

    localparam sym_t SYM_DOT  = 2'd0;
    localparam sym_t SYM_DASH = 2'd1;
    localparam sym_t SYM_GAP  = 2'd2;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [2:0] MAX_SYMBOLS = 3'd5;
    localparam logic [2:0] OVERLONG    = 3'd6;

    // result-side action of one microcode step
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_PAT,
        EMIT_GAP,
        EMIT_DEC
    } emit_t;

    // sequencing of the step counter
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_DISPATCH,
        SEQ_REPEAT
    } seq_t;

    typedef struct packed {
        emit_t emit;
        logic  last;
        seq_t  seq;
        upc_t  target;
    } ctrl_word_t;

    // microcode addresses
    localparam upc_t UA_FETCH   = 3'd0;
    localparam upc_t UA_ENC_SYM = 3'd1;
    localparam upc_t UA_ENC_GAP = 3'd2;
    localparam upc_t UA_DEC     = 3'd3;
    localparam upc_t UA_SPC0    = 3'd4;
    localparam upc_t UA_SPC1    = 3'd5;
    localparam upc_t UA_SPC2    = 3'd6;
    localparam upc_t UA_SPARE   = 3'd7;

    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t w;
        unique case (addr)
            UA_FETCH:   w = '{EMIT_NONE, 1'b0, SEQ_DISPATCH, UA_FETCH};
            UA_ENC_SYM: w = '{EMIT_PAT,  1'b0, SEQ_REPEAT,   UA_ENC_GAP};
            UA_ENC_GAP: w = '{EMIT_GAP,  1'b1, SEQ_JUMP,     UA_FETCH};
            UA_DEC:     w = '{EMIT_DEC,  1'b1, SEQ_JUMP,     UA_FETCH};
            UA_SPC0:    w = '{EMIT_GAP,  1'b0, SEQ_NEXT,     UA_FETCH};
            UA_SPC1:    w = '{EMIT_GAP,  1'b0, SEQ_NEXT,     UA_FETCH};
            UA_SPC2:    w = '{EMIT_GAP,  1'b1, SEQ_JUMP,     UA_FETCH};
            default:    w = '{EMIT_NONE, 1'b0, SEQ_JUMP,     UA_FETCH};
        endcase
        return w;
    endfunction

    // character to code: length in 7:5, dash pattern in 4:0 (first symbol LSB)
    function automatic logic [7:0] code_of(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            "a": r = 8'h42;  "b": r = 8'h81;  "c": r = 8'h85;  "d": r = 8'h61;
            "e": r = 8'h20;  "f": r = 8'h84;  "g": r = 8'h63;  "h": r = 8'h80;
            "i": r = 8'h40;  "j": r = 8'h8E;  "k": r = 8'h65;  "l": r = 8'h82;
            "m": r = 8'h43;  "n": r = 8'h41;  "o": r = 8'h67;  "p": r = 8'h86;
            "q": r = 8'h8B;  "r": r = 8'h62;  "s": r = 8'h60;  "t": r = 8'h21;
            "u": r = 8'h64;  "v": r = 8'h88;  "w": r = 8'h66;  "x": r = 8'h89;
            "y": r = 8'h8D;  "z": r = 8'h83;  "0": r = 8'hBF;  "1": r = 8'hBE;
            "2": r = 8'hBC;  "3": r = 8'hB8;  "4": r = 8'hB0;  "5": r = 8'hA0;
            "6": r = 8'hA1;  "7": r = 8'hA3;  "8": r = 8'hA7;  "9": r = 8'hAF;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] char_of(input logic [7:0] code);
        logic [7:0] r;
        unique case (code)
            8'h42: r = "a";  8'h81: r = "b";  8'h85: r = "c";  8'h61: r = "d";
            8'h20: r = "e";  8'h84: r = "f";  8'h63: r = "g";  8'h80: r = "h";
            8'h40: r = "i";  8'h8E: r = "j";  8'h65: r = "k";  8'h82: r = "l";
            8'h43: r = "m";  8'h41: r = "n";  8'h67: r = "o";  8'h86: r = "p";
            8'h8B: r = "q";  8'h62: r = "r";  8'h60: r = "s";  8'h21: r = "t";
            8'h64: r = "u";  8'h88: r = "v";  8'h66: r = "w";  8'h89: r = "x";
            8'h8D: r = "y";  8'h83: r = "z";  8'hBF: r = "0";  8'hBE: r = "1";
            8'hBC: r = "2";  8'hB8: r = "3";  8'hB0: r = "4";  8'hA0: r = "5";
            8'hA1: r = "6";  8'hA3: r = "7";  8'hA7: r = "8";  8'hAF: r = "9";
            default: r = 8'h00;
        endcase
        return r[6:0];
    endfunction

endpackage

@@ hw/rtl/morse_codec_core.sv @@
// Encode: a character steps through fetch, a step per symbol, an empty loop
// test and a gap; a space through fetch and gap steps SPC0, SPC1, SPC2; an
// unknown byte through fetch, the empty loop test and a gap. Decode steps
// through fetch and update/emit for each symbol. The step counter makes one
// step per cycle unless fetch waits on s_valid or the output register stalls.
// Reset (aresetn low, synchronous) clears mode, decode state, step count, valid.
module morse_codec_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_in,
    input  logic [1:0]           s_symbol_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_symbol_out,
    output logic [6:0]           m_char_out,
    output logic                 m_last
);
    import morse_pkg::*;

    ctrl_word_t ctrl;

    upc_t       upc_reg, upc_next;
    logic       mode_reg, mode_next;
    logic [2:0] enc_cnt_reg, enc_cnt_next;
    logic [4:0] enc_pat_reg, enc_pat_next;
    sym_t       sym_reg, sym_next;
    logic [4:0] pattern_bits_reg, pattern_bits_next;
    logic [2:0] symbol_count_reg, symbol_count_next;
    logic [1:0] gap_run_reg, gap_run_next;
    logic       m_valid_reg, m_valid_next;
    sym_t       m_symbol_reg, m_symbol_next;
    logic [6:0] m_char_reg, m_char_next;
    logic       m_last_reg, m_last_next;

    logic       out_free;
    logic       emit_now;
    logic       step_go;
    logic       dec_hit;
    logic [6:0] dec_char;
    logic [7:0] folded;
    logic [7:0] fetch_code;
    upc_t       dispatch_addr;

    always_comb begin
        ctrl     = ucode_rom(upc_reg);
        out_free = !m_valid_reg || m_ready;

        folded = s_char_in;
        if (s_char_in >= "A" && s_char_in <= "Z") begin
            folded = s_char_in + 8'd32;
        end
        fetch_code = code_of(folded);

        if (mode_reg) begin
            dispatch_addr = UA_DEC;
        end else if (s_char_in == ASCII_SPACE) begin
            dispatch_addr = UA_SPC0;
        end else begin
            dispatch_addr = UA_ENC_SYM;
        end

        // decoder: a gap ends pending symbols, or completes a run of three
        dec_hit = (sym_reg == SYM_GAP) &&
                  ((symbol_count_reg != 3'd0) || (gap_run_reg == 2'd2));
        if (symbol_count_reg == 3'd0) begin
            dec_char = ASCII_SPACE[6:0];
        end else if (symbol_count_reg <= MAX_SYMBOLS) begin
            dec_char = char_of({symbol_count_reg, pattern_bits_reg});
        end else begin
            dec_char = 7'd0;
        end

        unique case (ctrl.emit)
            EMIT_NONE: emit_now = 1'b0;
            EMIT_PAT:  emit_now = (enc_cnt_reg != 3'd0);
            EMIT_GAP:  emit_now = 1'b1;
            EMIT_DEC:  emit_now = dec_hit;
            default:   emit_now = 1'b0;
        endcase

        if (ctrl.seq == SEQ_DISPATCH) begin
            step_go = s_valid;
        end else begin
            step_go = !emit_now || out_free;
        end
        s_ready = (ctrl.seq == SEQ_DISPATCH);

        upc_next          = upc_reg;
        mode_next         = cfg_we ? cfg_wdata : mode_reg;
        enc_cnt_next      = enc_cnt_reg;
        enc_pat_next      = enc_pat_reg;
        sym_next          = sym_reg;
        pattern_bits_next = pattern_bits_reg;
        symbol_count_next = symbol_count_reg;
        gap_run_next      = gap_run_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_symbol_next     = m_symbol_reg;
        m_char_next       = m_char_reg;
        m_last_next       = m_last_reg;

        if (step_go) begin
            unique case (ctrl.seq)
                SEQ_NEXT:     upc_next = upc_reg + 3'd1;
                SEQ_JUMP:     upc_next = ctrl.target;
                SEQ_DISPATCH: upc_next = dispatch_addr;
                SEQ_REPEAT:   upc_next = (enc_cnt_reg != 3'd0) ? upc_reg : ctrl.target;
                default:      upc_next = UA_FETCH;
            endcase

            if (ctrl.seq == SEQ_DISPATCH) begin
                enc_cnt_next = fetch_code[7:5];
                enc_pat_next = fetch_code[4:0];
                sym_next     = s_symbol_in;
            end

            if (emit_now) begin
                m_valid_next  = 1'b1;
                m_last_next   = ctrl.last;
                m_symbol_next = SYM_DOT;
                m_char_next   = 7'd0;
                unique case (ctrl.emit)
                    EMIT_PAT: m_symbol_next = {1'b0, enc_pat_reg[0]};
                    EMIT_GAP: m_symbol_next = SYM_GAP;
                    EMIT_DEC: m_char_next   = dec_char;
                    default:  m_symbol_next = SYM_DOT;
                endcase
            end

            if (ctrl.emit == EMIT_PAT && enc_cnt_reg != 3'd0) begin
                enc_cnt_next = enc_cnt_reg - 3'd1;
                enc_pat_next = {1'b0, enc_pat_reg[4:1]};
            end

            if (ctrl.emit == EMIT_DEC) begin
                if (sym_reg == SYM_DOT || sym_reg == SYM_DASH) begin
                    gap_run_next = 2'd0;
                    if (symbol_count_reg < MAX_SYMBOLS) begin
                        if (sym_reg == SYM_DASH) begin
                            pattern_bits_next = pattern_bits_reg |
                                (5'd1 << symbol_count_reg);
                        end
                        symbol_count_next = symbol_count_reg + 3'd1;
                    end else begin
                        symbol_count_next = OVERLONG;
                    end
                end else if (sym_reg == SYM_GAP) begin
                    if (symbol_count_reg != 3'd0) begin
                        pattern_bits_next = 5'd0;
                        symbol_count_next = 3'd0;
                        gap_run_next      = 2'd0;
                    end else if (gap_run_reg == 2'd2) begin
                        gap_run_next = 2'd0;
                    end else begin
                        gap_run_next = gap_run_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg          <= UA_FETCH;
            mode_reg         <= 1'b0;
            pattern_bits_reg <= 5'd0;
            symbol_count_reg <= 3'd0;
            gap_run_reg      <= 2'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            upc_reg          <= upc_next;
            mode_reg         <= mode_next;
            pattern_bits_reg <= pattern_bits_next;
            symbol_count_reg <= symbol_count_next;
            gap_run_reg      <= gap_run_next;
            m_valid_reg      <= m_valid_next;
        end
        enc_cnt_reg  <= enc_cnt_next;
        enc_pat_reg  <= enc_pat_next;
        sym_reg      <= sym_next;
        m_symbol_reg <= m_symbol_next;
        m_char_reg   <= m_char_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_symbol_out = m_symbol_reg;
    assign m_char_out   = m_char_reg;
    assign m_last       = m_last_reg;

endmodule
